// ===== rtl/ssm_pkg.sv =====
package ssm_pkg;

    localparam int unsigned W_Q    = 48;
    localparam int unsigned W_A    = 82;
    localparam int unsigned W_Y    = 98;
    localparam int unsigned W_P    = 114;
    localparam int unsigned W_REM  = 49;
    localparam int unsigned W_CNT  = 7;

    // iteration counts of the shared unit
    localparam logic [W_CNT-1:0] CNT_SQ   = 7'd49;
    localparam logic [W_CNT-1:0] CNT_ROOT = 7'd49;
    localparam logic [W_CNT-1:0] CNT_KD   = 7'd32;
    localparam logic [W_CNT-1:0] CNT_TERM = 7'd81;
    localparam logic [W_CNT-1:0] CNT_UNIT = 7'd33;
    localparam logic [W_CNT-1:0] CNT_DT   = 7'd32;

    // 9.8 in q.32, rounded to nearest
    localparam logic [35:0] GRAV_Q32 = 36'd42090679501;

    localparam logic [31:0] RST_SPRING = 32'd1179648000;
    localparam logic [47:0] RST_REST   = 48'd4294967296;
    localparam logic [31:0] RST_MASS   = 32'd4756330;
    localparam logic [31:0] RST_DT     = 32'd343597;

    typedef enum logic [2:0] {
        CFG_SPRING = 3'd0,
        CFG_REST   = 3'd1,
        CFG_MASS   = 3'd2,
        CFG_ANCH_X = 3'd3,
        CFG_ANCH_Y = 3'd4,
        CFG_DT     = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_op;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [W_CNT-1:0] cnt;
        logic [W_A-1:0]   a;
        logic [W_REM-1:0] x_init;
        logic [W_Y-1:0]   y_init;
    } t_unit_req;

    typedef struct packed {
        logic           done;
        logic [W_P-1:0] prod;
        logic [W_A-1:0] quo;
    } t_unit_rsp;

    typedef struct packed {
        logic [W_Q-1:0] val;
        logic           sat;
    } t_sat;

endpackage

// ===== rtl/ssm_in_if.sv =====
interface ssm_in_if import ssm_pkg::*;;
    logic           valid;
    logic           ready;
    logic           opcode;
    logic [W_Q-1:0] load_pos_x;
    logic [W_Q-1:0] load_pos_y;
    logic [W_Q-1:0] load_vel_x;
    logic [W_Q-1:0] load_vel_y;

    modport source (output valid, opcode, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
                    input ready);
    modport sink (input valid, opcode, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
                  output ready);
endinterface

// ===== rtl/ssm_out_if.sv =====
interface ssm_out_if import ssm_pkg::*;;
    logic           valid;
    logic           ready;
    logic [W_Q-1:0] out_pos_x;
    logic [W_Q-1:0] out_pos_y;
    logic [W_Q-1:0] out_vel_x;
    logic [W_Q-1:0] out_vel_y;
    logic [W_Q-1:0] spring_length;
    logic [W_Q-1:0] elapsed_time;
    logic           degenerate;
    logic           saturated;

    modport source (output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                    spring_length, elapsed_time, degenerate, saturated,
                    input ready);
    modport sink (input valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                  spring_length, elapsed_time, degenerate, saturated,
                  output ready);
endinterface

// ===== rtl/ssm_unit.sv =====
module ssm_unit import ssm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    logic             r_busy, r_done;
    t_op              r_op;
    logic [W_CNT-1:0] r_cnt;
    logic [W_A-1:0]   r_a;
    logic [W_P-1:0]   r_x;
    logic [W_Y-1:0]   r_y;
    logic [W_A-1:0]   r_q;

    logic [W_P-1:0]   n_x;
    logic [W_Y-1:0]   n_y;
    logic [W_A-1:0]   n_q;

    logic [W_REM:0]   div_t, div_d;
    logic [51:0]      sq_t, sq_trial;

    always_comb begin
        div_t    = {r_x[W_REM-1:0], r_y[W_Y-1]};
        div_d    = {1'b0, r_a[W_REM-1:0]};
        sq_t     = {r_x[49:0], r_y[W_Y-1 -: 2]};
        sq_trial = {1'b0, r_q[48:0], 2'b01};
        n_x      = r_x;
        n_y      = r_y;
        n_q      = r_q;
        unique case (r_op)
            OP_MUL: begin
                // msb-first shift and add
                n_x = {r_x[W_P-2:0], 1'b0} + (r_y[W_Y-1] ? {{(W_P-W_A){1'b0}}, r_a} : '0);
                n_y = {r_y[W_Y-2:0], 1'b0};
            end
            OP_DIV: begin
                // restoring division, one quotient bit
                if (div_t >= div_d) begin
                    n_x = {{(W_P-W_REM){1'b0}}, W_REM'(div_t - div_d)};
                    n_q = {r_q[W_A-2:0], 1'b1};
                end else begin
                    n_x = {{(W_P-W_REM){1'b0}}, div_t[W_REM-1:0]};
                    n_q = {r_q[W_A-2:0], 1'b0};
                end
                n_y = {r_y[W_Y-2:0], 1'b0};
            end
            OP_SQRT: begin
                // two radicand bits, one root bit
                if (sq_t >= sq_trial) begin
                    n_x = {{(W_P-52){1'b0}}, sq_t - sq_trial};
                    n_q = {r_q[W_A-2:0], 1'b1};
                end else begin
                    n_x = {{(W_P-52){1'b0}}, sq_t};
                    n_q = {r_q[W_A-2:0], 1'b0};
                end
                n_y = {r_y[W_Y-3:0], 2'b00};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= i_req.cnt;
                r_a    <= i_req.a;
                r_x    <= {{(W_P-W_REM){1'b0}}, i_req.x_init};
                r_y    <= i_req.y_init;
                r_q    <= '0;
            end else if (r_busy) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_q   <= n_q;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == W_CNT'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_x;
    assign o_rsp.quo  = r_q;

endmodule

// ===== rtl/slip_spring_mass_euler_step.sv =====
// planar spring-loaded inverted pendulum, one explicit euler step per item
// i_in carries one item: opcode 0 loads position and velocity and clears the
// elapsed time, opcode 1 advances the state by one time step. o_out returns
// exactly one result item per input item: the new state, the leg length,
// the elapsed time and the degenerate and saturated flags.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must do so only while the block is idle, which the block does not
// enforce. unknown indices are ignored. every multiply, divide and the
// square root run one bit per cycle through one shared shift/add/subtract
// unit, one pass after the other: two 49-bit squares, a 49-step root, a
// 32-bit multiply, the 81-step force division, two 33-step unit divisions,
// two 33-bit multiplies and four 32-bit time-step multiplies. a step with
// a zero leg length skips the force passes and applies gravity only.
// i_in.ready is high only when idle, in the cycle after the result is
// registered, so a new item is taken only once the last one is through.
// if the receiver stalls, the finished result waits in the output register
// and the following one is held until the register is free; i_in.ready
// stays low meanwhile. reset restores the register defaults and clears the
// position, velocity and elapsed time, and holds i_in.ready low.
module slip_spring_mass_euler_step import ssm_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ssm_in_if.sink         i_in,
    ssm_out_if.source      o_out,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [W_Q-1:0] i_cfg_data
);

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001,
        S_MXX  = 18'h00002,
        S_MYY  = 18'h00004,
        S_SQRT = 18'h00008,
        S_CHK  = 18'h00010,
        S_MKD  = 18'h00020,
        S_DIVT = 18'h00040,
        S_DIVX = 18'h00080,
        S_DIVY = 18'h00100,
        S_MAX  = 18'h00200,
        S_MAY  = 18'h00400,
        S_GRAV = 18'h00800,
        S_DVX  = 18'h01000,
        S_DVY  = 18'h02000,
        S_DAX  = 18'h04000,
        S_DAY  = 18'h08000,
        S_TIME = 18'h10000,
        S_FIN  = 18'h20000
    } t_state;

    function automatic t_sat sat_mag(input logic [W_A-1:0] mag, input logic neg);
        t_sat           r;
        logic [W_Q-1:0] lim;
        logic [W_Q-1:0] m;
        lim = neg ? {1'b1, {(W_Q-1){1'b0}}} : {1'b0, {(W_Q-1){1'b1}}};
        if (mag[W_A-1:W_Q] != '0 || mag[W_Q-1:0] > lim) begin
            m     = lim;
            r.sat = 1'b1;
        end else begin
            m     = mag[W_Q-1:0];
            r.sat = 1'b0;
        end
        r.val = neg ? (~m + 1'b1) : m;
        return r;
    endfunction

    function automatic t_sat clip49(input logic [W_Q:0] s);
        t_sat r;
        if (s[W_Q] != s[W_Q-1]) begin
            r.sat = 1'b1;
            r.val = s[W_Q] ? {1'b1, {(W_Q-1){1'b0}}} : {1'b0, {(W_Q-1){1'b1}}};
        end else begin
            r.sat = 1'b0;
            r.val = s[W_Q-1:0];
        end
        return r;
    endfunction

    // configuration
    logic [31:0]    r_spring, r_mass, r_dt;
    logic [W_Q-1:0] r_rest, r_anch_x, r_anch_y;

    // architectural state
    logic [W_Q-1:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y, r_sim;

    // step working registers
    t_state         r_state, n_state;
    logic           r_launch;
    logic [48:0]    r_mx, r_my, r_len, r_dmag;
    logic           r_dxn, r_dyn, r_dneg;
    logic [96:0]    r_sqx, r_sqy;
    logic [80:0]    r_kd, r_term;
    logic [32:0]    r_ex, r_ey;
    logic [W_Q-1:0] r_ax, r_ay, r_len_out;
    logic           r_degen, r_sat;

    // output register
    logic           r_out_valid;
    logic [W_Q-1:0] r_o_px, r_o_py, r_o_vx, r_o_vy, r_o_len, r_o_time;
    logic           r_o_degen, r_o_sat;

    t_unit_req      req;
    t_unit_rsp      rsp;

    logic           accept;
    logic [48:0]    dx, dy, mx, my;
    logic [49:0]    d50;
    logic [31:0]    mass_nz;
    logic [W_Q-1:0] dt_v, dt_vmag, dt_tgt;
    t_sat           acc_s, dt_s, upd_s, grav_s;
    logic [W_Q:0]   t49;

    ssm_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    assign i_in.ready = i_rst_n && (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        dx      = {r_pos_x[W_Q-1], r_pos_x} - {r_anch_x[W_Q-1], r_anch_x};
        dy      = {r_pos_y[W_Q-1], r_pos_y} - {r_anch_y[W_Q-1], r_anch_y};
        mx      = dx[48] ? (~dx + 1'b1) : dx;
        my      = dy[48] ? (~dy + 1'b1) : dy;
        d50     = {2'b00, r_rest} - {1'b0, r_len};
        mass_nz = (r_mass == '0) ? 32'd1 : r_mass;
        // acceleration component from the unit product
        acc_s   = sat_mag(rsp.prod[W_P-1:32],
                          r_dneg ^ ((r_state == S_MAX) ? r_dxn : r_dyn));
        grav_s  = clip49({r_ay[W_Q-1], r_ay} - {13'd0, GRAV_Q32});
        t49     = {1'b0, r_sim} + {17'd0, r_dt};
        unique case (r_state)
            S_DVX:   begin dt_v = r_vel_x; dt_tgt = r_pos_x; end
            S_DVY:   begin dt_v = r_vel_y; dt_tgt = r_pos_y; end
            S_DAX:   begin dt_v = r_ax;    dt_tgt = r_vel_x; end
            default: begin dt_v = r_ay;    dt_tgt = r_vel_y; end
        endcase
        dt_vmag = dt_v[W_Q-1] ? (~dt_v + 1'b1) : dt_v;
        dt_s    = sat_mag({34'd0, rsp.prod[79:32]}, dt_v[W_Q-1]);
        upd_s   = clip49({dt_tgt[W_Q-1], dt_tgt} + {dt_s.val[W_Q-1], dt_s.val});
    end

    // operand selection for the shared unit
    always_comb begin
        req.start  = 1'b0;
        req.op     = OP_MUL;
        req.cnt    = CNT_DT;
        req.a      = '0;
        req.x_init = '0;
        req.y_init = '0;
        unique case (r_state)
            S_MXX: begin
                req.start  = r_launch;
                req.cnt    = CNT_SQ;
                req.a      = {33'd0, r_mx};
                req.y_init = {r_mx, 49'd0};
            end
            S_MYY: begin
                req.start  = r_launch;
                req.cnt    = CNT_SQ;
                req.a      = {33'd0, r_my};
                req.y_init = {r_my, 49'd0};
            end
            S_SQRT: begin
                req.start  = r_launch;
                req.op     = OP_SQRT;
                req.cnt    = CNT_ROOT;
                req.y_init = {1'b0, r_sqx} + {1'b0, r_sqy};
            end
            S_MKD: begin
                req.start  = r_launch;
                req.cnt    = CNT_KD;
                req.a      = {33'd0, r_dmag};
                req.y_init = {r_spring, 66'd0};
            end
            S_DIVT: begin
                req.start  = r_launch;
                req.op     = OP_DIV;
                req.cnt    = CNT_TERM;
                req.a      = {50'd0, mass_nz};
                req.y_init = {r_kd, 17'd0};
            end
            S_DIVX: begin
                // numerator mx * 2^32, quotient known to fit 33 bits
                req.start  = r_launch;
                req.op     = OP_DIV;
                req.cnt    = CNT_UNIT;
                req.a      = {33'd0, r_len};
                req.x_init = {1'b0, r_mx[48:1]};
                req.y_init = {r_mx[0], 97'd0};
            end
            S_DIVY: begin
                req.start  = r_launch;
                req.op     = OP_DIV;
                req.cnt    = CNT_UNIT;
                req.a      = {33'd0, r_len};
                req.x_init = {1'b0, r_my[48:1]};
                req.y_init = {r_my[0], 97'd0};
            end
            S_MAX: begin
                req.start  = r_launch;
                req.cnt    = CNT_UNIT;
                req.a      = {1'b0, r_term};
                req.y_init = {r_ex, 65'd0};
            end
            S_MAY: begin
                req.start  = r_launch;
                req.cnt    = CNT_UNIT;
                req.a      = {1'b0, r_term};
                req.y_init = {r_ey, 65'd0};
            end
            S_DVX, S_DVY, S_DAX, S_DAY: begin
                req.start  = r_launch;
                req.cnt    = CNT_DT;
                req.a      = {34'd0, dt_vmag};
                req.y_init = {r_dt, 66'd0};
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = i_in.opcode ? S_MXX : S_FIN;
            S_MXX:  if (rsp.done) n_state = S_MYY;
            S_MYY:  if (rsp.done) n_state = S_SQRT;
            S_SQRT: if (rsp.done) n_state = S_CHK;
            S_CHK:  n_state = (r_len == '0) ? S_GRAV : S_MKD;
            S_MKD:  if (rsp.done) n_state = S_DIVT;
            S_DIVT: if (rsp.done) n_state = S_DIVX;
            S_DIVX: if (rsp.done) n_state = S_DIVY;
            S_DIVY: if (rsp.done) n_state = S_MAX;
            S_MAX:  if (rsp.done) n_state = S_MAY;
            S_MAY:  if (rsp.done) n_state = S_GRAV;
            S_GRAV: n_state = S_DVX;
            S_DVX:  if (rsp.done) n_state = S_DVY;
            S_DVY:  if (rsp.done) n_state = S_DAX;
            S_DAX:  if (rsp.done) n_state = S_DAY;
            S_DAY:  if (rsp.done) n_state = S_TIME;
            S_TIME: n_state = S_FIN;
            S_FIN:  if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
            r_spring    <= RST_SPRING;
            r_rest      <= RST_REST;
            r_mass      <= RST_MASS;
            r_anch_x    <= '0;
            r_anch_y    <= '0;
            r_dt        <= RST_DT;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_sim       <= '0;
        end else begin
            r_state  <= n_state;
            // start the unit on entry to each state
            r_launch <= (n_state != r_state);

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SPRING: r_spring <= i_cfg_data[31:0];
                    CFG_REST:   r_rest   <= i_cfg_data;
                    CFG_MASS:   r_mass   <= i_cfg_data[31:0];
                    CFG_ANCH_X: r_anch_x <= i_cfg_data;
                    CFG_ANCH_Y: r_anch_y <= i_cfg_data;
                    CFG_DT:     r_dt     <= i_cfg_data[31:0];
                    default: ;
                endcase
            end

            // in S_FIN the output register is refilled below instead
            if (o_out.valid && o_out.ready && r_state != S_FIN) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_degen   <= 1'b0;
                        r_sat     <= 1'b0;
                        r_len_out <= '0;
                        if (!i_in.opcode) begin
                            r_pos_x <= i_in.load_pos_x;
                            r_pos_y <= i_in.load_pos_y;
                            r_vel_x <= i_in.load_vel_x;
                            r_vel_y <= i_in.load_vel_y;
                            r_sim   <= '0;
                        end else begin
                            r_mx  <= mx;
                            r_my  <= my;
                            r_dxn <= dx[48];
                            r_dyn <= dy[48];
                        end
                    end
                end
                S_MXX:  if (rsp.done) r_sqx <= rsp.prod[96:0];
                S_MYY:  if (rsp.done) r_sqy <= rsp.prod[96:0];
                S_SQRT: if (rsp.done) r_len <= rsp.quo[48:0];
                S_CHK: begin
                    if (r_len[48]) begin
                        r_len_out <= '1;
                        r_sat     <= 1'b1;
                    end else begin
                        r_len_out <= r_len[W_Q-1:0];
                    end
                    // zero leg length: gravity only
                    if (r_len == '0) begin
                        r_degen <= 1'b1;
                        r_ax    <= '0;
                        r_ay    <= '0;
                    end
                    r_dneg <= d50[49];
                    r_dmag <= d50[49] ? 49'(~d50 + 1'b1) : d50[48:0];
                end
                S_MKD:  if (rsp.done) r_kd   <= rsp.prod[80:0];
                S_DIVT: if (rsp.done) r_term <= rsp.quo[80:0];
                S_DIVX: if (rsp.done) r_ex   <= rsp.quo[32:0];
                S_DIVY: if (rsp.done) r_ey   <= rsp.quo[32:0];
                S_MAX: begin
                    if (rsp.done) begin
                        r_ax <= acc_s.val;
                        if (acc_s.sat) r_sat <= 1'b1;
                    end
                end
                S_MAY: begin
                    if (rsp.done) begin
                        r_ay <= acc_s.val;
                        if (acc_s.sat) r_sat <= 1'b1;
                    end
                end
                S_GRAV: begin
                    r_ay <= grav_s.val;
                    if (grav_s.sat) r_sat <= 1'b1;
                end
                S_DVX, S_DVY, S_DAX, S_DAY: begin
                    if (rsp.done) begin
                        if (dt_s.sat || upd_s.sat) r_sat <= 1'b1;
                        priority case (1'b1)
                            r_state == S_DVX: r_pos_x <= upd_s.val;
                            r_state == S_DVY: r_pos_y <= upd_s.val;
                            r_state == S_DAX: r_vel_x <= upd_s.val;
                            default:          r_vel_y <= upd_s.val;
                        endcase
                    end
                end
                S_TIME: begin
                    if (t49[W_Q]) begin
                        r_sim <= '1;
                        r_sat <= 1'b1;
                    end else begin
                        r_sim <= t49[W_Q-1:0];
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_px      <= r_pos_x;
                        r_o_py      <= r_pos_y;
                        r_o_vx      <= r_vel_x;
                        r_o_vy      <= r_vel_y;
                        r_o_len     <= r_len_out;
                        r_o_time    <= r_sim;
                        r_o_degen   <= r_degen;
                        r_o_sat     <= r_sat;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_pos_x     = r_o_px;
    assign o_out.out_pos_y     = r_o_py;
    assign o_out.out_vel_x     = r_o_vx;
    assign o_out.out_vel_y     = r_o_vy;
    assign o_out.spring_length = r_o_len;
    assign o_out.elapsed_time  = r_o_time;
    assign o_out.degenerate    = r_o_degen;
    assign o_out.saturated     = r_o_sat;

endmodule
